>>> design/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types, widths, codes and the Morse code table of the fault beacon.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int MSG_LEN_DEF = 32;

    localparam int ET_W      = 16;
    localparam int RC_W      = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int GAP_W     = 19;

    localparam logic [ET_W-1:0] ET_RESET = 16'd200;
    localparam logic [RC_W-1:0] RC_RESET = 4'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT  = 1'd1;

    localparam logic [1:0] MODE_TICK       = 2'd0;
    localparam logic [1:0] MODE_WRITE      = 2'd1;
    localparam logic [1:0] MODE_FAULT      = 2'd2;
    localparam logic [1:0] MODE_FAST_FAULT = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] char_index;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic key_on;
        logic busy_res;
        logic faulted;
        logic power_off;
    } out_item_t;

    // Element count in [7:5], pattern in [4:0] (dash = 1, first element in bit 0).
    // Letters A-Z at 0..25, digits 0-9 at 26..35.
    function automatic logic [7:0] code_entry(input logic [5:0] idx);
        logic [7:0] e;
        case (idx)
            6'd0:  e = 8'h42;
            6'd1:  e = 8'h81;
            6'd2:  e = 8'h85;
            6'd3:  e = 8'h61;
            6'd4:  e = 8'h20;
            6'd5:  e = 8'h84;
            6'd6:  e = 8'h63;
            6'd7:  e = 8'h80;
            6'd8:  e = 8'h40;
            6'd9:  e = 8'h8E;
            6'd10: e = 8'h65;
            6'd11: e = 8'h82;
            6'd12: e = 8'h43;
            6'd13: e = 8'h41;
            6'd14: e = 8'h67;
            6'd15: e = 8'h86;
            6'd16: e = 8'h8B;
            6'd17: e = 8'h62;
            6'd18: e = 8'h60;
            6'd19: e = 8'h21;
            6'd20: e = 8'h64;
            6'd21: e = 8'h88;
            6'd22: e = 8'h66;
            6'd23: e = 8'h89;
            6'd24: e = 8'h8D;
            6'd25: e = 8'h83;
            6'd26: e = 8'hBF;
            6'd27: e = 8'hBE;
            6'd28: e = 8'hBC;
            6'd29: e = 8'hB8;
            6'd30: e = 8'hB0;
            6'd31: e = 8'hA0;
            6'd32: e = 8'hA1;
            6'd33: e = 8'hA3;
            6'd34: e = 8'hA7;
            6'd35: e = 8'hAF;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

>>> design/mfb_in_if.sv
// ----------------------------------------------------------------------------
// mfb_in_if
// Valid/ready channel carrying beacon input beats.
// ----------------------------------------------------------------------------
interface mfb_in_if import mfb_pkg::*; ();

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

>>> design/mfb_out_if.sv
// ----------------------------------------------------------------------------
// mfb_out_if
// Valid/ready channel carrying beacon result beats.
// ----------------------------------------------------------------------------
interface mfb_out_if import mfb_pkg::*; ();

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

>>> design/mfb_ram.sv
// ----------------------------------------------------------------------------
// mfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfb_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/mfb_seq.sv
// ----------------------------------------------------------------------------
// mfb_seq
// Beacon sequencer: message store, element timing and pass control.
// ----------------------------------------------------------------------------
module mfb_seq import mfb_pkg::*; #(
    parameter int MSG_LEN = MSG_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  in_item_t        item,
    input  logic [ET_W-1:0] element_ticks,
    input  logic [RC_W-1:0] repeat_count,
    output out_item_t       res
);

    localparam int AW    = $clog2(MSG_LEN);
    localparam int PTR_W = $clog2(MSG_LEN + 1);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TEXT      = 3'd1;
    localparam logic [2:0] PH_SEND      = 3'd2;
    localparam logic [2:0] PH_POST_ELEM = 3'd3;
    localparam logic [2:0] PH_POST_CHAR = 3'd4;
    localparam logic [2:0] PH_POST_WORD = 3'd5;

    logic [2:0]       phase_reg,  phase_next;
    logic [GAP_W-1:0] gap_reg,    gap_next;
    logic [PTR_W-1:0] ptr_reg,    ptr_next;
    logic [4:0]       pat_reg,    pat_next;
    logic [2:0]       left_reg,   left_next;
    logic [RC_W-1:0]  passes_reg, passes_next;
    logic             fault_reg,  fault_next;
    logic             halted_reg, halted_next;
    logic             byp_hit_reg, byp_hit_next;
    logic [7:0]       byp_data_reg;

    logic [7:0]       rd_data;
    logic [7:0]       cur_char;
    logic [7:0]       folded;
    logic             is_letter;
    logic             is_digit;
    logic [5:0]       tbl_idx;
    logic [7:0]       tbl_entry;
    logic [GAP_W-1:0] et_x1;
    logic [GAP_W-1:0] et_x3;
    logic [GAP_W-1:0] et_x7;
    logic             do_char;
    logic             do_elem;
    logic [4:0]       elem_pat;
    logic [2:0]       elem_left;
    logic [RC_W-1:0]  passes_sel;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    mfb_ram #(
        .WIDTH (8),
        .DEPTH (MSG_LEN)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (item.char_code),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign cur_char  = byp_hit_reg ? byp_data_reg : rd_data;
    assign folded    = (cur_char inside {[8'h61:8'h7A]}) ? (cur_char & 8'h5F) : cur_char;
    assign is_letter = folded inside {[8'h41:8'h5A]};
    assign is_digit  = cur_char inside {[8'h30:8'h39]};
    assign tbl_idx   = is_letter ? 6'(folded - 8'h41) : 6'(cur_char - 8'h30 + 8'd26);
    assign tbl_entry = code_entry(tbl_idx);

    assign et_x1 = GAP_W'(element_ticks);
    assign et_x3 = (et_x1 << 1) + et_x1;
    assign et_x7 = (et_x1 << 3) - et_x1;

    assign wr_addr = AW'(item.char_index);

    always_comb
    begin
        phase_next  = phase_reg;
        gap_next    = gap_reg;
        ptr_next    = ptr_reg;
        pat_next    = pat_reg;
        left_next   = left_reg;
        passes_next = passes_reg;
        fault_next  = fault_reg;
        halted_next = halted_reg;
        do_char     = 1'b0;
        do_elem     = 1'b0;
        elem_pat    = pat_reg;
        elem_left   = left_reg;
        passes_sel  = repeat_count;
        wr_en       = 1'b0;

        if (step && !halted_reg)
        begin
            case (item.mode)
                MODE_TICK:
                begin
                    if (phase_reg == PH_TEXT)
                    begin
                        do_char = 1'b1;
                    end
                    else if (phase_reg > PH_POST_WORD)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        if (gap_reg != '0)
                        begin
                            gap_next = gap_reg - 1'b1;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_SEND:
                                begin
                                    gap_next   = et_x1;
                                    phase_next = PH_POST_ELEM;
                                end
                                PH_POST_ELEM:
                                begin
                                    do_elem = 1'b1;
                                end
                                default:
                                begin
                                    do_char = 1'b1;
                                end
                            endcase
                        end
                    end

                    if (do_char)
                    begin
                        if (ptr_reg >= PTR_W'(MSG_LEN))
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + PTR_W'(1);
                            if (cur_char == 8'h00)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (is_letter || is_digit)
                            begin
                                elem_pat  = tbl_entry[4:0];
                                elem_left = tbl_entry[7:5];
                                do_elem   = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_POST_WORD;
                                gap_next   = et_x7;
                            end
                        end
                    end

                    if (do_elem)
                    begin
                        if (elem_left == 3'd0)
                        begin
                            phase_next = PH_POST_CHAR;
                            gap_next   = et_x3;
                        end
                        else
                        begin
                            gap_next   = elem_pat[0] ? et_x3 : et_x1;
                            pat_next   = elem_pat >> 1;
                            left_next  = elem_left - 3'd1;
                            phase_next = PH_SEND;
                        end
                    end

                    if (fault_reg && phase_next == PH_IDLE)
                    begin
                        if (passes_reg != '0)
                        begin
                            phase_next  = PH_TEXT;
                            ptr_next    = '0;
                            passes_next = passes_reg - 1'b1;
                        end
                        else
                        begin
                            halted_next = 1'b1;
                        end
                    end
                end
                MODE_WRITE:
                begin
                    wr_en = (int'(item.char_index) < MSG_LEN);
                end
                default:
                begin
                    passes_sel  = (item.mode == MODE_FAULT) ? repeat_count : RC_W'(1);
                    fault_next  = 1'b1;
                    phase_next  = PH_TEXT;
                    ptr_next    = '0;
                    passes_next = (passes_sel == '0) ? '0 : passes_sel - 1'b1;
                end
            endcase
        end
    end

    // hold the read port on the next pointer; forward a same-address write
    assign rd_addr      = (ptr_next >= PTR_W'(MSG_LEN)) ? '0 : AW'(ptr_next);
    assign byp_hit_next = wr_en && (wr_addr == rd_addr);

    assign res.key_on    = !halted_next && (phase_next == PH_SEND);
    assign res.busy_res  = !halted_next && (phase_next != PH_IDLE);
    assign res.faulted   = fault_next;
    assign res.power_off = halted_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            gap_reg     <= '0;
            ptr_reg     <= '0;
            pat_reg     <= '0;
            left_reg    <= '0;
            passes_reg  <= '0;
            fault_reg   <= 1'b0;
            halted_reg  <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            gap_reg     <= gap_next;
            ptr_reg     <= ptr_next;
            pat_reg     <= pat_next;
            left_reg    <= left_next;
            passes_reg  <= passes_next;
            fault_reg   <= fault_next;
            halted_reg  <= halted_next;
            byp_hit_reg <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= item.char_code;
    end

endmodule

>>> design/morse_fault_beacon.sv
// ----------------------------------------------------------------------------
// morse_fault_beacon
// Keys a stored fault message out as Morse code, paced by tick beats.
// ----------------------------------------------------------------------------
// Every input beat (tick, message byte write, fault start or fast fault start)
// yields exactly one result beat holding key_on, busy_res, faulted and
// power_off as they stand after that beat. The block takes one beat per
// clock: the whole step, including the code table lookup and the message
// store read, is combinational because the store's registered read port is
// always aimed at the next character. An output register plus one skid entry
// let the block take a beat while a result is still waiting; ready drops only
// when both are full. Timing is counted in ticks of element_ticks each; after
// the last pass the block raises power_off and ignores every beat until reset.
// ----------------------------------------------------------------------------
module morse_fault_beacon import mfb_pkg::*; #(
    parameter int MSG_LEN = MSG_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    mfb_in_if.sink               item,
    mfb_out_if.source            result
);

    logic [ET_W-1:0] element_ticks_reg;
    logic [RC_W-1:0] repeat_count_reg;

    logic            accept;
    out_item_t       step_res;

    logic            out_valid_reg;
    out_item_t       out_data_reg;
    logic            skid_valid_reg;
    out_item_t       skid_data_reg;
    logic            out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_ticks_reg <= ET_RESET;
            repeat_count_reg  <= RC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ELEMENT_TICKS: element_ticks_reg <= cfg_data[ET_W-1:0];
                CFG_REPEAT_COUNT:  repeat_count_reg  <= cfg_data[RC_W-1:0];
                default:           ;
            endcase
        end
    end

    assign item.ready = !skid_valid_reg;
    assign accept     = item.valid && item.ready;

    mfb_seq #(
        .MSG_LEN (MSG_LEN)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .item          (item.data),
        .element_ticks (element_ticks_reg),
        .repeat_count  (repeat_count_reg),
        .res           (step_res)
    );

    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= step_res;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= step_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule
